[sv/salc_pkg.sv]
// ----------------------------------------------------------------------------
// salc_pkg: shared constants and types of the LRU tag cache
// Register indexes, opcode values, result field widths and the lookup
// status handed from the way logic to the top level.
// ----------------------------------------------------------------------------
package salc_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = CFG_IDX_W'(1);

	// request payload
	localparam int   ADDR_W   = 32;
	localparam logic OP_WRITE = 1'b1;

	// result payload
	localparam int WAY_FIELD_W = 2;
	localparam int COUNT_W     = 32;

	// outcome of one lookup
	typedef struct packed {
		logic                   hit;
		logic [WAY_FIELD_W-1:0] way;
	} lookup_status_t;

endpackage

[sv/salc_tag_store.sv]
// ----------------------------------------------------------------------------
// salc_tag_store: per-set line storage
// One row per set holds every way's valid, dirty, age and tag. One read and
// one write port, registered read data, a written-since-reset flag per row
// and a forward path for a read of the row being written in the same cycle.
// ----------------------------------------------------------------------------
module salc_tag_store #(
	parameter int SETS  = 64,
	parameter int SET_W = 6,
	parameter int ROW_W = 96
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [SET_W-1:0] rd_set,
	input  logic             wr_en,
	input  logic [SET_W-1:0] wr_set,
	input  logic [ROW_W-1:0] wr_row,
	output logic [ROW_W-1:0] rd_row
);

	logic [ROW_W-1:0] mem [SETS];
	logic [ROW_W-1:0] mem_rd_q;
	logic [ROW_W-1:0] fwd_row_q;
	logic [SETS-1:0]  row_init_q;
	logic             init_rd_q;
	logic             fwd_q;

	// array write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_set] <= wr_row;
		end
	end

	// array read, data registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_rd_q  <= mem[rd_set];
			fwd_row_q <= wr_row;
		end
	end

	// row-written flags and forward select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_init_q <= '0;
			init_rd_q  <= 1'b0;
			fwd_q      <= 1'b0;
		end else begin
			if (rd_en) begin
				init_rd_q <= row_init_q[rd_set];
				fwd_q     <= wr_en && (wr_set == rd_set);
			end
			if (wr_en) begin
				row_init_q[wr_set] <= 1'b1;
			end
		end
	end

	// a row never written reads as all zero
	always_comb begin
		if (fwd_q) begin
			rd_row = fwd_row_q;
		end else if (init_rd_q) begin
			rd_row = mem_rd_q;
		end else begin
			rd_row = '0;
		end
	end

endmodule

[sv/salc_way_logic.sv]
// ----------------------------------------------------------------------------
// salc_way_logic: parallel tag compare and LRU update of one set
// Finds the hit way, else the first free way, else the oldest way, and
// builds the updated row: ages, valid, tag and dirty mark.
// ----------------------------------------------------------------------------
module salc_way_logic
	import salc_pkg::*;
#(
	parameter int WAYS  = 4,
	parameter int TAG_W = 20,
	parameter int WAY_W = 2,
	parameter int CNT_W = 3,
	parameter int LINE_W = TAG_W + WAY_W + 2,
	parameter int ROW_W  = WAYS * LINE_W
) (
	input  logic [ROW_W-1:0] row_in,
	input  logic [TAG_W-1:0] tag,
	input  logic             is_write,
	input  logic             write_back,
	input  logic [CNT_W-1:0] n_active,
	output logic [ROW_W-1:0] row_out,
	output lookup_status_t   status
);

	// line layout, lsb first: tag, age, dirty, valid
	localparam int AGE_W   = WAY_W;
	localparam int AGE_LSB = TAG_W;
	localparam int DRT_BIT = TAG_W + AGE_W;
	localparam int VLD_BIT = TAG_W + AGE_W + 1;
	localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);

	logic [WAYS-1:0]  vld, drt, act, match, free;
	logic [TAG_W-1:0] tg [WAYS];
	logic [AGE_W-1:0] ag [WAYS];

	logic             hit, found_free, age_all;
	logic [WAY_W-1:0] hit_way, free_way, vic_way, sel;
	logic [AGE_W-1:0] best, limit;

	// unpack and per-way compare
	for (genvar k = 0; k < WAYS; k++) begin : g_way
		assign vld[k]   = row_in[k*LINE_W + VLD_BIT];
		assign drt[k]   = row_in[k*LINE_W + DRT_BIT];
		assign ag[k]    = row_in[k*LINE_W + AGE_LSB +: AGE_W];
		assign tg[k]    = row_in[k*LINE_W +: TAG_W];
		assign act[k]   = CNT_W'(k) < n_active;
		assign match[k] = act[k] && vld[k] && (tg[k] == tag);
		assign free[k]  = act[k] && !vld[k];
	end

	// lowest matching way, lowest free way, oldest way
	always_comb begin
		hit_way  = '0;
		free_way = '0;
		for (int k = WAYS - 1; k >= 0; k--) begin
			if (match[k]) begin
				hit_way = WAY_W'(k);
			end
			if (free[k]) begin
				free_way = WAY_W'(k);
			end
		end
		best    = '0;
		vic_way = '0;
		for (int k = 0; k < WAYS; k++) begin
			if (act[k] && (ag[k] > best)) begin
				best    = ag[k];
				vic_way = WAY_W'(k);
			end
		end
	end

	assign hit        = |match;
	assign found_free = |free;
	assign age_all    = !hit && found_free;

	always_comb begin
		priority if (hit) begin
			sel = hit_way;
		end else if (found_free) begin
			sel = free_way;
		end else begin
			sel = vic_way;
		end
	end

	assign limit = ag[sel];

	// updated row
	always_comb begin
		row_out = row_in;
		for (int k = 0; k < WAYS; k++) begin
			if (WAY_W'(k) == sel) begin
				row_out[k*LINE_W + AGE_LSB +: AGE_W] = '0;
				if (hit) begin
					row_out[k*LINE_W + DRT_BIT] = is_write ? write_back : drt[k];
				end else begin
					row_out[k*LINE_W + VLD_BIT] = 1'b1;
					row_out[k*LINE_W + DRT_BIT] = is_write && write_back;
					row_out[k*LINE_W +: TAG_W]  = tag;
				end
			end else if (act[k] && vld[k] && (age_all || (ag[k] < limit))
					&& (ag[k] < AGE_MAX)) begin
				row_out[k*LINE_W + AGE_LSB +: AGE_W] = ag[k] + AGE_W'(1);
			end
		end
	end

	assign status.hit = hit;
	assign status.way = WAY_FIELD_W'(sel);

endmodule

[sv/set_associative_lru_cache.sv]
// ----------------------------------------------------------------------------
// set_associative_lru_cache: tag-only set-associative cache with LRU refill
// Looks up each access, reports hit or miss with the way used, and keeps
// running hit, miss, read and write counters.
// ----------------------------------------------------------------------------
// Usage:
//  Request channel: in_valid / in_stall with operation (0 read, 1 write)
//  and address. Result channel: out_valid / out_stall with hit, way and the
//  four counters as they stand after the access.
//  Config channel: cfg_valid / cfg_ready (ready always high), cfg_index 0
//  selects write_back, 1 selects ways_in_use; other indexes are ignored.
//  Write config only while no request is in flight.
//  Throughput: one request per cycle while no result stalls. The set's row
//  is read from the tag array into a register as the request is taken;
//  the lookup stage then compares the ways, writes the row back and
//  registers the result.
//  A request to the set being written back is forwarded, so back-to-back
//  accesses to one set cost nothing extra.
//  Stall: a stalled result holds; one more request is taken into the
//  lookup stage, after which in_stall rises until the result drains.
//  Reset: counters clear, write_back = 1, ways_in_use = 4, and every set
//  reads as empty through a per-set written flag; no clearing pass.
//  SETS and BLOCK_BYTES are powers of two.
// ----------------------------------------------------------------------------
module set_associative_lru_cache
	import salc_pkg::*;
#(
	parameter int SETS        = 64,
	parameter int WAYS        = 4,
	parameter int BLOCK_BYTES = 64,
	parameter int ADDR_BITS   = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// config
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// request
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   operation,
	input  logic [ADDR_W-1:0]      address,
	// result
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   hit,
	output logic [WAY_FIELD_W-1:0] way,
	output logic [COUNT_W-1:0]     hit_count,
	output logic [COUNT_W-1:0]     miss_count,
	output logic [COUNT_W-1:0]     read_count,
	output logic [COUNT_W-1:0]     write_count
);

	localparam int EFF_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam int OFF_W    = $clog2(BLOCK_BYTES);
	localparam int IDX_BITS = $clog2(SETS);
	localparam int SET_W    = (IDX_BITS > 0) ? IDX_BITS : 1;
	localparam int TAG_RAW  = EFF_BITS - OFF_W - IDX_BITS;
	localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int CNT_W    = $clog2(WAYS + 1);
	localparam int LINE_W   = TAG_W + WAY_W + 2;
	localparam int ROW_W    = WAYS * LINE_W;
	localparam logic [ADDR_W-1:0] ADDR_MASK =
		(EFF_BITS >= ADDR_W) ? '1 : ADDR_W'((64'd1 << EFF_BITS) - 64'd1);
	localparam logic [ADDR_W-1:0] SET_MASK = ADDR_W'(SETS - 1);

	logic                  write_back_q;
	logic [CFG_DATA_W-1:0] ways_q;
	logic [CNT_W-1:0]      n_active;

	logic [ADDR_W-1:0] blk;
	logic [SET_W-1:0]  set_in;
	logic              accept, advance;

	logic              valid_s1, is_write_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [SET_W-1:0]  set_s1;
	logic [ROW_W-1:0]  row_rd, row_wr;
	lookup_status_t    status;

	logic                   out_valid_q, hit_s2;
	logic [WAY_FIELD_W-1:0] way_s2;
	logic [COUNT_W-1:0]     hits_q, misses_q, reads_q, writes_q;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_back_q <= 1'b1;
			ways_q       <= CFG_DATA_W'(4);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WRITE_BACK:  write_back_q <= cfg_data[0];
				CFG_WAYS_IN_USE: ways_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// active way count, clamped to 1..WAYS
	always_comb begin
		priority if (ways_q == '0) begin
			n_active = CNT_W'(1);
		end else if (32'(ways_q) > 32'(WAYS)) begin
			n_active = CNT_W'(WAYS);
		end else begin
			n_active = CNT_W'(ways_q);
		end
	end

	// handshake
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// address split
	assign blk    = (address & ADDR_MASK) >> OFF_W;
	assign set_in = SET_W'(blk & SET_MASK);

	// lookup stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_write_s1 <= (operation == OP_WRITE);
			tag_s1      <= TAG_W'(blk >> IDX_BITS);
			set_s1      <= set_in;
		end
	end

	salc_tag_store #(
		.SETS  (SETS),
		.SET_W (SET_W),
		.ROW_W (ROW_W)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_set (set_in),
		.wr_en  (advance),
		.wr_set (set_s1),
		.wr_row (row_wr),
		.rd_row (row_rd)
	);

	salc_way_logic #(
		.WAYS  (WAYS),
		.TAG_W (TAG_W),
		.WAY_W (WAY_W),
		.CNT_W (CNT_W)
	) u_ways (
		.row_in     (row_rd),
		.tag        (tag_s1),
		.is_write   (is_write_s1),
		.write_back (write_back_q),
		.n_active   (n_active),
		.row_out    (row_wr),
		.status     (status)
	);

	// result register and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hits_q      <= '0;
			misses_q    <= '0;
			reads_q     <= '0;
			writes_q    <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				hits_q      <= hits_q + COUNT_W'(status.hit);
				misses_q    <= misses_q + COUNT_W'(!status.hit);
				reads_q     <= reads_q + COUNT_W'(!is_write_s1);
				writes_q    <= writes_q + COUNT_W'(is_write_s1 || !status.hit);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_s2 <= status.hit;
			way_s2 <= status.way;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_s2;
	assign way         = way_s2;
	assign hit_count   = hits_q;
	assign miss_count  = misses_q;
	assign read_count  = reads_q;
	assign write_count = writes_q;

	// checks
	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> COUNT_W'(hits_q + misses_q) ==
			COUNT_W'($past(hits_q) + $past(misses_q) + COUNT_W'(1)))
		else $error("hit plus miss count did not step by one");

	a_counters_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(hits_q) && $stable(misses_q) && $stable(reads_q)
			&& $stable(writes_q))
		else $error("counters moved without a lookup");

	a_stall_needs_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("request stalled with the lookup stage free");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(hit_s2) && $stable(way_s2))
		else $error("stalled result changed");

endmodule

[tb/tb_set_associative_lru_cache.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_associative_lru_cache: self-checking bench for the LRU tag cache
// A directed table walks through empty-set fills, extreme addresses, LRU
// replacement, duplicate tags and out-of-range way counts. Random phases
// follow, each under its own write policy and way count. Every result is
// compared field by field against table data or a cycle-free cache predictor.
// ----------------------------------------------------------------------------
module tb_set_associative_lru_cache;
	import salc_pkg::*;

	localparam int SETS        = 64;
	localparam int WAYS        = 4;
	localparam int BLOCK_BYTES = 64;
	localparam int OFFSET_W    = $clog2(BLOCK_BYTES);
	localparam int SET_W       = $clog2(SETS);
	localparam int TAG_W       = ADDR_W - SET_W - OFFSET_W;
	localparam int LINES       = SETS * WAYS;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 70;
	localparam int NUM_PHASES  = 7;

	localparam logic OP_READ = ~OP_WRITE;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST = '1;

	typedef struct {
		logic                   hit;
		logic [WAY_FIELD_W-1:0] way;
		logic [COUNT_W-1:0]     hits;
		logic [COUNT_W-1:0]     misses;
		logic [COUNT_W-1:0]     reads;
		logic [COUNT_W-1:0]     writes;
	} access_result_t;

	typedef enum logic {ROW_ACCESS, ROW_CONFIG} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic                  op;
		logic [ADDR_W-1:0]     addr;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		bit                    known;
		access_result_t        result;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic                   operation;
	logic [ADDR_W-1:0]      address;
	logic                   out_valid;
	logic                   out_stall;
	logic                   hit;
	logic [WAY_FIELD_W-1:0] way;
	logic [COUNT_W-1:0]     hit_count;
	logic [COUNT_W-1:0]     miss_count;
	logic [COUNT_W-1:0]     read_count;
	logic [COUNT_W-1:0]     write_count;

	set_associative_lru_cache #(
		.SETS        (SETS),
		.WAYS        (WAYS),
		.BLOCK_BYTES (BLOCK_BYTES),
		.ADDR_BITS   (ADDR_W)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.address     (address),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.way         (way),
		.hit_count   (hit_count),
		.miss_count  (miss_count),
		.read_count  (read_count),
		.write_count (write_count)
	);

	// predictor state: tag array, policy registers, running counters
	logic                 tag_valid [LINES];
	logic [TAG_W-1:0]     tag_store [LINES];
	logic                 tag_dirty [LINES];
	logic [1:0]           tag_age   [LINES];
	logic                 write_back_mode;
	logic [CFG_DATA_W-1:0] ways_setting;
	logic [COUNT_W-1:0]   hits_total;
	logic [COUNT_W-1:0]   misses_total;
	logic [COUNT_W-1:0]   reads_total;
	logic [COUNT_W-1:0]   writes_total;

	access_result_t expected_results[$];
	stim_row_t      directed_rows[$];
	logic [TAG_W-1:0] tag_pool [6];
	logic [SET_W-1:0] set_pool [4];

	int  error_count;
	int  requests_sent;
	int  results_checked;
	int  hits_seen;
	int  cfg_writes;
	bit  idle_enabled;
	bit  long_hold_req;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic int unsigned active_way_count();
		if (ways_setting == 0)
			return 1;
		if (ways_setting > WAYS)
			return WAYS;
		return 32'(ways_setting);
	endfunction

	// way w becomes youngest; valid active ways younger than limit age by one
	function automatic void promote_way(int unsigned base, int unsigned n, int unsigned w,
		int unsigned limit);
		for (int unsigned k = 0; k < n; k++) begin
			if (k != w && tag_valid[base + k] && tag_age[base + k] < limit &&
				tag_age[base + k] < WAYS - 1)
				tag_age[base + k] = tag_age[base + k] + 2'd1;
		end
		tag_age[base + w] = 2'd0;
	endfunction

	function automatic access_result_t cache_access(logic op, logic [ADDR_W-1:0] addr);
		int unsigned      set_idx;
		int unsigned      base;
		int unsigned      n;
		int unsigned      w;
		int unsigned      oldest;
		logic [TAG_W-1:0] tag;
		bit               found;
		bit               free_found;
		access_result_t   r;
		set_idx = 32'(addr[OFFSET_W +: SET_W]);
		tag     = addr[ADDR_W-1 -: TAG_W];
		base    = set_idx * WAYS;
		n       = active_way_count();
		found   = 0;
		w       = 0;
		// lowest matching way wins when tags are duplicated
		for (int unsigned k = 0; k < n; k++) begin
			if (!found && tag_valid[base + k] && tag_store[base + k] == tag) begin
				found = 1;
				w = k;
			end
		end
		if (found) begin
			promote_way(base, n, w, 32'(tag_age[base + w]));
			if (op == OP_WRITE)
				tag_dirty[base + w] = write_back_mode;
			hits_total++;
			if (op == OP_WRITE)
				writes_total++;
			else
				reads_total++;
		end else begin
			free_found = 0;
			for (int unsigned k = 0; k < n; k++) begin
				if (!free_found && !tag_valid[base + k]) begin
					free_found = 1;
					w = k;
				end
			end
			if (free_found) begin
				promote_way(base, n, w, 256);
			end else begin
				// oldest way is the victim, lowest index on ties
				oldest = 0;
				w = 0;
				for (int unsigned k = 0; k < n; k++) begin
					if (tag_age[base + k] > oldest) begin
						oldest = 32'(tag_age[base + k]);
						w = k;
					end
				end
				promote_way(base, n, w, oldest);
			end
			tag_valid[base + w] = 1'b1;
			tag_store[base + w] = tag;
			tag_dirty[base + w] = (op == OP_WRITE) ? write_back_mode : 1'b0;
			misses_total++;
			writes_total++;
			if (op == OP_READ)
				reads_total++;
		end
		r.hit    = found;
		r.way    = WAY_FIELD_W'(w);
		r.hits   = hits_total;
		r.misses = misses_total;
		r.reads  = reads_total;
		r.writes = writes_total;
		return r;
	endfunction

	function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
		logic [CFG_DATA_W-1:0] data);
		if (idx == CFG_WRITE_BACK)
			write_back_mode = data[0];
		else if (idx == CFG_WAYS_IN_USE)
			ways_setting = data;
	endfunction

	// ---------------------------------------------------------------- table helpers

	function automatic logic [ADDR_W-1:0] line_addr(logic [TAG_W-1:0] tag,
		logic [SET_W-1:0] set_idx, logic [OFFSET_W-1:0] off);
		return {tag, set_idx, off};
	endfunction

	function automatic void add_access(logic op, logic [ADDR_W-1:0] addr);
		stim_row_t row;
		row = '{kind: ROW_ACCESS, op: op, addr: addr, idx: '0, data: '0, known: 0,
			result: '{hit: 0, way: 0, hits: 0, misses: 0, reads: 0, writes: 0}};
		directed_rows.push_back(row);
	endfunction

	function automatic void add_known(logic op, logic [ADDR_W-1:0] addr, logic h,
		logic [WAY_FIELD_W-1:0] w, int hc, int mc, int rc, int wc);
		stim_row_t row;
		row = '{kind: ROW_ACCESS, op: op, addr: addr, idx: '0, data: '0, known: 1,
			result: '{hit: h, way: w, hits: hc, misses: mc, reads: rc, writes: wc}};
		directed_rows.push_back(row);
	endfunction

	function automatic void add_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		stim_row_t row;
		row = '{kind: ROW_CONFIG, op: OP_READ, addr: '0, idx: idx, data: data, known: 0,
			result: '{hit: 0, way: 0, hits: 0, misses: 0, reads: 0, writes: 0}};
		directed_rows.push_back(row);
	endfunction

	function automatic void build_directed();
		// empty cache after reset, address extremes
		add_known(OP_READ,  32'h0000_0000, 1'b0, 2'd0, 0, 1, 1, 1);
		add_known(OP_WRITE, 32'hFFFF_FFFF, 1'b0, 2'd0, 0, 2, 1, 2);
		add_known(OP_READ,  32'h0000_003F, 1'b1, 2'd0, 1, 2, 2, 2);
		add_known(OP_WRITE, 32'hFFFF_FFC0, 1'b1, 2'd0, 2, 2, 2, 3);
		add_known(OP_READ,  32'hFFFF_FFFF, 1'b1, 2'd0, 3, 2, 3, 3);
		// fill one set, refresh a way, then force LRU replacement
		add_access(OP_READ,  line_addr(20'd1, 6'd5, 6'd0));
		add_access(OP_WRITE, line_addr(20'd2, 6'd5, 6'd7));
		add_access(OP_READ,  line_addr(20'd3, 6'd5, 6'd63));
		add_access(OP_WRITE, line_addr(20'd4, 6'd5, 6'd1));
		add_access(OP_READ,  line_addr(20'd2, 6'd5, 6'd2));
		add_access(OP_READ,  line_addr(20'd5, 6'd5, 6'd3));
		add_access(OP_WRITE, line_addr(20'd6, 6'd5, 6'd4));
		// one active way replaces way 0 and leaves a duplicate tag in way 1
		add_access(OP_READ,  line_addr(20'h12345, 6'd9, 6'd0));
		add_access(OP_WRITE, line_addr(20'hABCDE, 6'd9, 6'd0));
		add_config(CFG_WAYS_IN_USE, 3'd1);
		add_access(OP_READ,  line_addr(20'hABCDE, 6'd9, 6'd5));
		// zero ways acts as one
		add_config(CFG_WAYS_IN_USE, 3'd0);
		add_access(OP_WRITE, line_addr(20'd7, 6'd5, 6'd9));
		// above the way count acts as all ways; duplicate hits the lower way
		add_config(CFG_WAYS_IN_USE, 3'd7);
		add_access(OP_READ,  line_addr(20'hABCDE, 6'd9, 6'd6));
		// write-through hit and miss
		add_config(CFG_WRITE_BACK, 3'd0);
		add_access(OP_WRITE, line_addr(20'd2, 6'd5, 6'd8));
		add_access(OP_WRITE, line_addr(20'd8, 6'd5, 6'd10));
		// unused register index is ignored
		add_config(CFG_SPARE_LAST, 3'd7);
	endfunction

	function automatic logic [ADDR_W-1:0] random_address();
		if ($urandom_range(0, 99) < 15)
			return $urandom;
		return line_addr(tag_pool[$urandom_range(0, 5)], set_pool[$urandom_range(0, 3)],
			OFFSET_W'($urandom));
	endfunction

	// ---------------------------------------------------------------- checking

	function automatic void compare_field(string name, logic [COUNT_W-1:0] exp_val,
		logic [COUNT_W-1:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
			error_count++;
		end
	endfunction

	function automatic void check_result();
		access_result_t e;
		if (expected_results.size() == 0) begin
			$error("result with no request outstanding");
			error_count++;
			return;
		end
		e = expected_results.pop_front();
		results_checked++;
		if (hit === 1'b1)
			hits_seen++;
		compare_field("hit",         COUNT_W'(e.hit), COUNT_W'(hit));
		compare_field("way",         COUNT_W'(e.way), COUNT_W'(way));
		compare_field("hit_count",   e.hits,   hit_count);
		compare_field("miss_count",  e.misses, miss_count);
		compare_field("read_count",  e.reads,  read_count);
		compare_field("write_count", e.writes, write_count);
	endfunction

	// result side: check, then decide next cycle's stall
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				check_result();
			if (long_hold_req) begin
				hold_left = HOLD_CYCLES;
				long_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idle_enabled && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- driving

	// offer one request and hold it until taken; predict at acceptance
	task automatic send_request(logic op, logic [ADDR_W-1:0] addr, bit known,
		access_result_t typed);
		access_result_t predicted;
		in_valid  <= 1'b1;
		operation <= op;
		address   <= addr;
		do @(posedge clk); while (in_stall);
		predicted = cache_access(op, addr);
		expected_results.push_back(known ? typed : predicted);
		requests_sent++;
	endtask

	task automatic request_gap();
		if (idle_enabled && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, data);
		cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------- main sequence
	initial begin
		access_result_t   none;
		logic             phase_wb   [NUM_PHASES];
		logic [2:0]       phase_ways [NUM_PHASES];
		none = '{hit: 0, way: 0, hits: 0, misses: 0, reads: 0, writes: 0};
		phase_wb   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		phase_ways = '{3'd4, 3'd2, 3'd3, 3'd1, 3'd7, 3'd0, 3'd4};

		error_count = 0;
		requests_sent = 0;
		results_checked = 0;
		hits_seen = 0;
		cfg_writes = 0;
		idle_enabled = 1;
		long_hold_req = 0;
		for (int i = 0; i < LINES; i++) begin
			tag_valid[i] = 1'b0;
			tag_store[i] = '0;
			tag_dirty[i] = 1'b0;
			tag_age[i]   = 2'd0;
		end
		write_back_mode = 1'b1;
		ways_setting    = 3'd4;
		hits_total   = '0;
		misses_total = '0;
		reads_total  = '0;
		writes_total = '0;

		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		operation <= OP_READ;
		address   <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		build_directed();
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CONFIG) begin
				wait_for_drain();
				write_register(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				send_request(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].known,
					directed_rows[i].result);
				request_gap();
			end
		end

		// random phases over a small pool of sets and tags so lines get reused
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		for (int i = 2; i < 6; i++)
			tag_pool[i] = TAG_W'($urandom);
		set_pool[0] = '0;
		set_pool[1] = '1;
		set_pool[2] = SET_W'($urandom);
		set_pool[3] = SET_W'($urandom);

		for (int p = 0; p < NUM_PHASES; p++) begin
			// sender pauses until all outstanding results are back
			wait_for_drain();
			idle_enabled = (p != 2) && (p != NUM_PHASES - 1);
			write_register(CFG_WRITE_BACK, {2'b00, phase_wb[p]});
			write_register(CFG_WAYS_IN_USE, phase_ways[p]);
			write_register(CFG_IDX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 1 && n == 30)
					long_hold_req = 1;
				send_request(logic'($urandom_range(0, 1)), random_address(), 0, none);
				request_gap();
			end
		end

		wait_for_drain();
		repeat (10) @(posedge clk);
		$display("Run covered %0d requests (%0d hits) and %0d register writes",
			requests_sent, hits_seen, cfg_writes);
		$display("across write-back/write-through and way counts 0 to 7, %0d results checked",
			results_checked);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[sim.f]
sv/salc_pkg.sv
sv/salc_tag_store.sv
sv/salc_way_logic.sv
sv/set_associative_lru_cache.sv
tb/tb_set_associative_lru_cache.sv
